[sv/ssp_pkg.sv]
// shared types, constants and register indexes of the scan segment person classifier
package ssp_pkg;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned THR_W      = 15;
  localparam int unsigned RANGE_W    = 17;
  localparam int unsigned COUNT_W    = 12;
  localparam int unsigned SQ_W       = 32;
  localparam int unsigned D2_W       = 33;
  localparam int unsigned RAD_W      = 34;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned MAX_CLUSTER_POINTS_DEF = 2048;

  localparam logic [D2_W-1:0]    DIAG2_MIN      = D2_W'(62500);
  localparam logic [D2_W-1:0]    DIAG2_MAX_NEAR = D2_W'(640000);
  localparam logic [D2_W-1:0]    DIAG2_MAX_MID  = D2_W'(422500);
  localparam logic [D2_W-1:0]    DIAG2_MAX_FAR  = D2_W'(490000);
  localparam logic [RANGE_W-1:0] BAND_NEAR      = RANGE_W'(5000);
  localparam logic [RANGE_W-1:0] BAND_MID       = RANGE_W'(10000);
  localparam int unsigned        CNT_MIN_NEAR   = 15;
  localparam int unsigned        CNT_MIN_MID    = 10;
  localparam int unsigned        CNT_MIN_FAR    = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AREA_MIN_X = 3'd0,
    CFG_AREA_MAX_X = 3'd1,
    CFG_AREA_MIN_Y = 3'd2,
    CFG_AREA_MAX_Y = 3'd3,
    CFG_JOIN_THR   = 3'd4,
    CFG_ROBOT_X    = 3'd5,
    CFG_ROBOT_Y    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic                      kind;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } in_req_t;

  typedef struct packed {
    logic                      is_person;
    logic                      from_scan_end;
    logic [COUNT_W-1:0]        num_points;
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
    logic [RANGE_W-1:0]        mean_range;
  } out_rsp_t;

endpackage

[sv/scan_segment_person_classifier_core.sv]
// top level: scan point segmentation into clusters with a person shape test
// One request at a time. A dropped point or an end of scan with no open cluster is handled
// in idle. A kept point that opens a cluster takes two squares for its range on the shared
// 16x16 multiplier, then the bit-serial root. A kept point that joins first takes three
// more squares for the join test and the decision.
// Closing a cluster adds the bit-serial mean division over the 29-bit range sum, then the
// shape test and the result register, and it stalls in push while an earlier result still
// waits. A point that closes one cluster goes on to open the next.
// A finished result waits in the output register while the next request is taken.
module scan_segment_person_classifier_core import ssp_pkg::*; #(
  parameter int unsigned MAX_CLUSTER_POINTS = MAX_CLUSTER_POINTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_req_t               in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_rsp_t              out_rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned CNT_W = $clog2(MAX_CLUSTER_POINTS + 1);
  localparam int unsigned SUM_W = RANGE_W + CNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_JT0, S_JDX, S_JDY, S_JDEC, S_RDX, S_RDY, S_RSQ, S_RWAIT,
    S_DIV, S_DWAIT, S_PWX, S_PWY, S_PWM, S_PDEC, S_PUSH
  } state_e;

  logic signed [COORD_W-1:0] amin_x_q, amax_x_q, amin_y_q, amax_y_q;
  logic signed [COORD_W-1:0] rob_x_q, rob_y_q;
  logic [THR_W-1:0]          thr_q;

  state_e                    state_q;
  logic                      open_q;
  logic signed [COORD_W-1:0] px_q, py_q, prev_x_q, prev_y_q;
  logic signed [COORD_W-1:0] bmin_x_q, bmax_x_q, bmin_y_q, bmax_y_q;
  logic [CNT_W-1:0]          count_q;
  logic [SUM_W-1:0]          sum_q;
  logic [D2_W-1:0]           acc_q;
  logic [SQ_W-1:0]           t2_q, m2_q;
  logic [RANGE_W-1:0]        mean_q;
  logic                      end_q, start_next_q, add_mode_q, person_q;
  logic                      out_valid_q;
  out_rsp_t                  out_q;

  logic [COORD_W-1:0]        mul_a, mul_b;
  logic [SQ_W-1:0]           prod;
  logic [COORD_W-1:0]        wx, wy, wm;
  logic                      in_area, join_ok, band_ok, shape_ok;
  logic [D2_W+3:0]           m2_25;
  logic                      sq_done, div_done;
  logic [RANGE_W-1:0]        root;
  logic [SUM_W-1:0]          quot;

  function automatic logic [COORD_W-1:0] abs_diff(logic signed [COORD_W-1:0] a,
                                                  logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    return d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amin_x_q <= 16'sd0;
      amax_x_q <= 16'sd10000;
      amin_y_q <= -16'sd1500;
      amax_y_q <= 16'sd4500;
      thr_q    <= 15'd100;
      rob_x_q  <= 16'sd0;
      rob_y_q  <= 16'sd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_AREA_MIN_X: amin_x_q <= $signed(cfg_wdata_i);
        CFG_AREA_MAX_X: amax_x_q <= $signed(cfg_wdata_i);
        CFG_AREA_MIN_Y: amin_y_q <= $signed(cfg_wdata_i);
        CFG_AREA_MAX_Y: amax_y_q <= $signed(cfg_wdata_i);
        CFG_JOIN_THR:   thr_q    <= cfg_wdata_i[THR_W-1:0];
        CFG_ROBOT_X:    rob_x_q  <= $signed(cfg_wdata_i);
        CFG_ROBOT_Y:    rob_y_q  <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_comb begin
    in_area = (amin_x_q < in_req_i.point_x) && (in_req_i.point_x < amax_x_q) &&
              (amin_y_q < in_req_i.point_y) && (in_req_i.point_y < amax_y_q);
    wx = abs_diff(bmax_x_q, bmin_x_q);
    wy = abs_diff(bmax_y_q, bmin_y_q);
    wm = (wx < wy) ? wx : wy;
    case (state_q)
      S_JT0: begin
        mul_a = COORD_W'(thr_q);
        mul_b = COORD_W'(thr_q);
      end
      S_JDX: begin
        mul_a = abs_diff(px_q, prev_x_q);
        mul_b = mul_a;
      end
      S_JDY: begin
        mul_a = abs_diff(py_q, prev_y_q);
        mul_b = mul_a;
      end
      S_RDX: begin
        mul_a = abs_diff(px_q, rob_x_q);
        mul_b = mul_a;
      end
      S_RDY: begin
        mul_a = abs_diff(py_q, rob_y_q);
        mul_b = mul_a;
      end
      S_PWX: begin
        mul_a = wx;
        mul_b = wx;
      end
      S_PWY: begin
        mul_a = wy;
        mul_b = wy;
      end
      S_PWM: begin
        mul_a = wm;
        mul_b = wm;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod    = mul_a * mul_b;
    join_ok = acc_q < {1'b0, t2_q};
    m2_25   = ({4'd0, 1'b0, m2_q} << 4) + ({4'd0, 1'b0, m2_q} << 3) + {4'd0, 1'b0, m2_q};
    shape_ok = (m2_q != '0) && ({4'd0, acc_q} <= m2_25) && (acc_q >= DIAG2_MIN);
    if (mean_q <= BAND_NEAR) begin
      band_ok = (count_q >= CNT_W'(CNT_MIN_NEAR)) && (acc_q <= DIAG2_MAX_NEAR);
    end else if (mean_q <= BAND_MID) begin
      band_ok = (count_q >= CNT_W'(CNT_MIN_MID)) && (acc_q <= DIAG2_MAX_MID);
    end else begin
      band_ok = (count_q >= CNT_W'(CNT_MIN_FAR)) && (acc_q <= DIAG2_MAX_FAR);
    end
  end

  ssp_isqrt #(.RAD_BITS(RAD_W)) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_RSQ),
    .radicand_i ({1'b0, acc_q}),
    .done_o     (sq_done),
    .root_o     (root)
  );

  ssp_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_DIV),
    .num_i      (sum_q),
    .den_i      ((count_q == '0) ? CNT_W'(1) : count_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      open_q       <= 1'b0;
      px_q         <= '0;
      py_q         <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      bmin_x_q     <= '0;
      bmax_x_q     <= '0;
      bmin_y_q     <= '0;
      bmax_y_q     <= '0;
      count_q      <= '0;
      sum_q        <= '0;
      acc_q        <= '0;
      t2_q         <= '0;
      m2_q         <= '0;
      mean_q       <= '0;
      end_q        <= 1'b0;
      start_next_q <= 1'b0;
      add_mode_q   <= 1'b0;
      person_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (out_ready_i && state_q != S_PUSH) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            px_q <= in_req_i.point_x;
            py_q <= in_req_i.point_y;
            if (in_req_i.kind) begin
              if (open_q) begin
                end_q        <= 1'b1;
                start_next_q <= 1'b0;
                state_q      <= S_DIV;
              end
            end else if (in_area) begin
              if (open_q) begin
                state_q <= S_JT0;
              end else begin
                prev_x_q   <= in_req_i.point_x;
                prev_y_q   <= in_req_i.point_y;
                add_mode_q <= 1'b0;
                state_q    <= S_RDX;
              end
            end
          end
        end
        S_JT0: begin
          t2_q    <= prod;
          state_q <= S_JDX;
        end
        S_JDX: begin
          acc_q   <= {1'b0, prod};
          state_q <= S_JDY;
        end
        S_JDY: begin
          acc_q   <= acc_q + {1'b0, prod};
          state_q <= S_JDEC;
        end
        S_JDEC: begin
          prev_x_q <= px_q;
          prev_y_q <= py_q;
          if (join_ok) begin
            if (px_q < bmin_x_q) bmin_x_q <= px_q;
            if (px_q > bmax_x_q) bmax_x_q <= px_q;
            if (py_q < bmin_y_q) bmin_y_q <= py_q;
            if (py_q > bmax_y_q) bmax_y_q <= py_q;
            add_mode_q <= 1'b1;
            state_q    <= (count_q < CNT_W'(MAX_CLUSTER_POINTS)) ? S_RDX : S_IDLE;
          end else begin
            end_q        <= 1'b0;
            start_next_q <= 1'b1;
            state_q      <= S_DIV;
          end
        end
        S_RDX: begin
          acc_q   <= {1'b0, prod};
          state_q <= S_RDY;
        end
        S_RDY: begin
          acc_q   <= acc_q + {1'b0, prod};
          state_q <= S_RSQ;
        end
        S_RSQ: begin
          state_q <= S_RWAIT;
        end
        S_RWAIT: begin
          if (sq_done) begin
            if (add_mode_q) begin
              count_q <= count_q + 1'b1;
              sum_q   <= sum_q + SUM_W'(root);
            end else begin
              open_q   <= 1'b1;
              count_q  <= CNT_W'(1);
              sum_q    <= SUM_W'(root);
              bmin_x_q <= px_q;
              bmax_x_q <= px_q;
              bmin_y_q <= py_q;
              bmax_y_q <= py_q;
            end
            state_q <= S_IDLE;
          end
        end
        S_DIV: begin
          state_q <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            mean_q  <= quot[RANGE_W-1:0];
            state_q <= S_PWX;
          end
        end
        S_PWX: begin
          acc_q   <= {1'b0, prod};
          state_q <= S_PWY;
        end
        S_PWY: begin
          acc_q   <= acc_q + {1'b0, prod};
          state_q <= S_PWM;
        end
        S_PWM: begin
          m2_q    <= prod;
          state_q <= S_PDEC;
        end
        S_PDEC: begin
          person_q <= shape_ok && band_ok;
          state_q  <= S_PUSH;
        end
        S_PUSH: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q          <= 1'b1;
            out_q.is_person      <= person_q;
            out_q.from_scan_end  <= end_q;
            out_q.num_points     <= COUNT_W'(count_q);
            out_q.box_min_x      <= bmin_x_q;
            out_q.box_min_y      <= bmin_y_q;
            out_q.box_max_x      <= bmax_x_q;
            out_q.box_max_y      <= bmax_y_q;
            out_q.mean_range     <= mean_q;
            open_q               <= 1'b0;
            add_mode_q           <= 1'b0;
            state_q              <= start_next_q ? S_RDX : S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef NO_ASSERTIONS
  a_sq_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> state_q == S_RWAIT) else $error("root done outside wait");
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DWAIT) else $error("divide done outside wait");
  a_open_has_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> count_q != '0) else $error("open cluster without points");
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_CLUSTER_POINTS)) else $error("count past limit");
  a_push_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PUSH && (!out_valid_q || out_ready_i) |=> out_valid_q && !open_q)
    else $error("result not loaded");
`endif

endmodule

[sv/ssp_isqrt.sv]
// digit-serial integer square root, one root bit per cycle
module ssp_isqrt import ssp_pkg::*; #(
  parameter int unsigned RAD_BITS = RAD_W
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [RAD_BITS-1:0]     radicand_i,
  output logic                    done_o,
  output logic [RAD_BITS/2-1:0]   root_o
);

  localparam int unsigned ROOT_W = RAD_BITS / 2;
  localparam int unsigned REM_W  = ROOT_W + 3;
  localparam int unsigned ITER_W = $clog2(ROOT_W + 1);

  logic [RAD_BITS-1:0] rad_q;
  logic [REM_W-1:0]    rem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [ITER_W-1:0]   cnt_q;
  logic                done_q;
  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    trial;
  logic                ge;

  always_comb begin
    rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_BITS-1 -: 2]};
    trial  = REM_W'({root_q, 2'b01});
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= ITER_W'(ROOT_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      rad_q  <= {rad_q[RAD_BITS-3:0], 2'b00};
      rem_q  <= ge ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[ROOT_W-2:0], ge};
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == ITER_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[sv/ssp_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
module ssp_div import ssp_pkg::*; #(
  parameter int unsigned NUM_W = 29,
  parameter int unsigned DEN_W = COUNT_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quotient_o
);

  localparam int unsigned ITER_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q;
  logic [ITER_W-1:0] cnt_q;
  logic              done_q;
  logic [DEN_W:0]    rem_sh;
  logic              ge;

  always_comb begin
    rem_sh = {rem_q, num_q[NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      cnt_q  <= ITER_W'(NUM_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      num_q  <= {num_q[NUM_W-2:0], ge};
      rem_q  <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == ITER_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule
